>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the circle draw block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/core/fcbd_pkg.sv
// Package with the constants, types and helper functions of the circle draw block.
`timescale 1ns / 1ps
`default_nettype none
package fcbd_pkg;

   localparam int IMAGE_WIDTH  = 256;
   localparam int IMAGE_HEIGHT = 256;

   localparam int COORD_W = 10;
   localparam int CHAN_W  = 8;
   localparam int PIX_W   = 3 * CHAN_W;
   localparam int ROW_W   = $clog2(IMAGE_HEIGHT);
   localparam int COL_W   = $clog2(IMAGE_WIDTH);
   localparam int PIXELS  = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int ADDR_W  = $clog2(PIXELS);

   // Signed offset from the centre, squared offset, and sum of two squares.
   localparam int OFS_W  = COORD_W + 2;
   localparam int SQ_W   = 2 * COORD_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int MUL_W  = COORD_W + 1;

   localparam int OP_W        = 2;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 24;

   localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
   localparam logic [OP_W-1:0] OP_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW = 2'd2;

   localparam logic [COORD_W:0] ROW_LIMIT = (COORD_W + 1)'(IMAGE_HEIGHT);
   localparam logic [COORD_W:0] COL_LIMIT = (COORD_W + 1)'(IMAGE_WIDTH);
   localparam logic [COORD_W:0] ROW_MAX   = (COORD_W + 1)'(IMAGE_HEIGHT - 1);
   localparam logic [COORD_W:0] COL_MAX   = (COORD_W + 1)'(IMAGE_WIDTH - 1);

   // One step of the circle walk as seen by the frame buffer side.
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic              done;
      logic [ADDR_W-1:0] addr;
   } walk_type;

   // Pixels are stored red in the low byte, then green, then blue.
   function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] old_px,
                                                 input logic [PIX_W-1:0] new_px);
      logic [PIX_W-1:0]  res;
      logic [CHAN_W:0]   sum;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         sum = {1'b0, old_px[i*CHAN_W +: CHAN_W]} + {1'b0, new_px[i*CHAN_W +: CHAN_W]};
         res[i*CHAN_W +: CHAN_W] = sum[CHAN_W:1];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/fcbd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fcbd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/fcbd_walk.sv
// Circle walker: clips the bounding square, then steps it one pixel a cycle.
`timescale 1ns / 1ps
`default_nettype none
module fcbd_walk
   import fcbd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COORD_W-1:0] crow,
   input  wire logic [COORD_W-1:0] ccol,
   input  wire logic [COORD_W-1:0] rad,
   output walk_type                walk
);

   typedef enum logic [5:0] {
      W_IDLE = 6'b000001,
      W_RR   = 6'b000010,
      W_MSQ  = 6'b000100,
      W_NSQ  = 6'b001000,
      W_BASE = 6'b010000,
      W_RUN  = 6'b100000
   } wstate_type;

   wstate_type state_ff, state_in;

   logic [COORD_W-1:0] rad_ff, mlo_ff, nlo_ff;
   logic [ROW_W-1:0]   prow_lo_ff, prow_hi_ff, pr_ff;
   logic [COL_W-1:0]   pcol_lo_ff, pcol_hi_ff, pc_ff;
   logic               empty_ff;
   logic [SQ_W-1:0]    rr_ff, msq_ff, n0sq_ff;
   logic signed [OFS_W-1:0] m_ff, n_ff;
   logic [DIST_W-1:0]  d_ff;
   logic [ADDR_W-1:0]  addr_ff, row_base_ff;

   // Clipping of the bounding square, taken from the centre and radius.
   logic [COORD_W-1:0] mlo, nlo, row_lo, col_lo;
   logic [COORD_W:0]   row_hi_sum, col_hi_sum, row_hi, col_hi;
   logic               empty;

   always_comb begin
      mlo        = (rad < crow) ? rad : crow;
      nlo        = (rad < ccol) ? rad : ccol;
      row_lo     = crow - mlo;
      col_lo     = ccol - nlo;
      row_hi_sum = {1'b0, crow} + {1'b0, rad};
      col_hi_sum = {1'b0, ccol} + {1'b0, rad};
      row_hi     = (row_hi_sum > ROW_MAX) ? ROW_MAX : row_hi_sum;
      col_hi     = (col_hi_sum > COL_MAX) ? COL_MAX : col_hi_sum;
      empty      = ({1'b0, row_lo} > ROW_MAX) || ({1'b0, col_lo} > COL_MAX);
   end

   // The shared multiplier serves the four setup steps in turn.
   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] prod;

   always_comb begin
      case (state_ff)
         W_RR: begin
            mul_a = {1'b0, rad_ff};
            mul_b = {1'b0, rad_ff};
         end
         W_MSQ: begin
            mul_a = {1'b0, mlo_ff};
            mul_b = {1'b0, mlo_ff};
         end
         W_NSQ: begin
            mul_a = {1'b0, nlo_ff};
            mul_b = {1'b0, nlo_ff};
         end
         W_BASE: begin
            mul_a = MUL_W'(prow_lo_ff);
            mul_b = MUL_W'(IMAGE_WIDTH);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Squares advance by 2k+1 as an offset k steps up by one.
   logic [SQ_W-1:0]   msq_step;
   logic [DIST_W-1:0] d_step, d_row;
   logic              last_col, last_row;

   always_comb begin
      msq_step = msq_ff + {{(SQ_W - OFS_W - 1){m_ff[OFS_W-1]}}, m_ff, 1'b1};
      d_step   = d_ff + {{(DIST_W - OFS_W - 1){n_ff[OFS_W-1]}}, n_ff, 1'b1};
      d_row    = {1'b0, msq_step} + {1'b0, n0sq_ff};
      last_col = (pc_ff == pcol_hi_ff);
      last_row = (pr_ff == prow_hi_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: if (start) begin
            state_in = W_RR;
         end
         W_RR:   state_in = W_MSQ;
         W_MSQ:  state_in = W_NSQ;
         W_NSQ:  state_in = W_BASE;
         W_BASE: state_in = empty_ff ? W_IDLE : W_RUN;
         W_RUN: if (last_col && last_row) begin
            state_in = W_IDLE;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         W_IDLE: if (start) begin
            rad_ff     <= rad;
            mlo_ff     <= mlo;
            nlo_ff     <= nlo;
            prow_lo_ff <= row_lo[ROW_W-1:0];
            pcol_lo_ff <= col_lo[COL_W-1:0];
            prow_hi_ff <= row_hi[ROW_W-1:0];
            pcol_hi_ff <= col_hi[COL_W-1:0];
            empty_ff   <= empty;
         end
         W_RR:  rr_ff   <= prod[SQ_W-1:0];
         W_MSQ: msq_ff  <= prod[SQ_W-1:0];
         W_NSQ: n0sq_ff <= prod[SQ_W-1:0];
         W_BASE: begin
            row_base_ff <= prod[ADDR_W-1:0] + ADDR_W'(pcol_lo_ff);
            addr_ff     <= prod[ADDR_W-1:0] + ADDR_W'(pcol_lo_ff);
            d_ff        <= {1'b0, msq_ff} + {1'b0, n0sq_ff};
            pr_ff       <= prow_lo_ff;
            pc_ff       <= pcol_lo_ff;
            m_ff        <= -$signed({2'b00, mlo_ff});
            n_ff        <= -$signed({2'b00, nlo_ff});
         end
         W_RUN: begin
            if (last_col) begin
               pr_ff       <= pr_ff + 1'b1;
               m_ff        <= m_ff + 1'b1;
               msq_ff      <= msq_step;
               d_ff        <= d_row;
               pc_ff       <= pcol_lo_ff;
               n_ff        <= -$signed({2'b00, nlo_ff});
               row_base_ff <= row_base_ff + ADDR_W'(IMAGE_WIDTH);
               addr_ff     <= row_base_ff + ADDR_W'(IMAGE_WIDTH);
            end else begin
               pc_ff   <= pc_ff + 1'b1;
               n_ff    <= n_ff + 1'b1;
               d_ff    <= d_step;
               addr_ff <= addr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      walk.valid = (state_ff == W_RUN);
      walk.hit   = (d_ff <= {1'b0, rr_ff});
      walk.addr  = addr_ff;
      walk.done  = ((state_ff == W_BASE) && empty_ff)
                || ((state_ff == W_RUN) && last_col && last_row);
   end

endmodule
`default_nettype wire

>>> rtl/core/filled_circle_blend_draw.sv
// Top level of the filled circle draw block with average blending.
//
// The block holds one frame of IMAGE_HEIGHT by IMAGE_WIDTH 24-bit pixels in a
// single-port-write, single-port-read RAM and returns one result beat for
// every request beat. A load, an unused operation or an off-image read
// is answered straight from the idle state, an in-image read from S_READ
// once the registered RAM read data is out. A draw runs setup steps on the
// shared multiplier (radius squared, each edge offset squared, the first
// row address), walks the bounding square clipped to the image and retires
// the last write in S_FINISH; the walk is not held by the one RAM read port
// feeding the read-blend-write of each hit pixel. One request is in flight at
// a time: req_tready is high only while idle and the result register is free
// or being emptied. Pixels must be loaded before they are read or drawn over.
`timescale 1ns / 1ps
`default_nettype none
module filled_circle_blend_draw
   import fcbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // row[9:0], col[19:10], radius[29:20], red[37:30], green[45:38],
   // blue[53:46], zero fill [55:54]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status[0]
   output logic                       rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_DRAW   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_W-1:0] row_in, col_in, rad_in;
   logic [PIX_W-1:0]   color_in;
   logic               accept, pix_in_frame;
   logic [2*MUL_W-1:0] lin_addr;
   logic [ADDR_W-1:0]  pix_addr;

   assign row_in   = req_tdata[9:0];
   assign col_in   = req_tdata[19:10];
   assign rad_in   = req_tdata[29:20];
   assign color_in = req_tdata[53:30];

   assign accept       = req_tvalid && req_tready;
   assign pix_in_frame = ({1'b0, row_in} < ROW_LIMIT) && ({1'b0, col_in} < COL_LIMIT);
   assign lin_addr = (2*MUL_W)'(row_in) * (2*MUL_W)'(IMAGE_WIDTH) + (2*MUL_W)'(col_in);
   assign pix_addr = lin_addr[ADDR_W-1:0];

   logic rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic rsp_status_ff, rsp_status_in;
   logic [PIX_W-1:0] color_ff;
   logic wr_valid_ff;
   logic [ADDR_W-1:0] wr_addr_ff;

   walk_type walk;
   logic     walk_start;
   logic [PIX_W-1:0] rd_data;
   logic ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [PIX_W-1:0] ram_wr_data;
   logic load_write, read_issue;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign walk_start = accept && (req_tuser == OP_DRAW);
   assign load_write = accept && (req_tuser == OP_LOAD) && pix_in_frame;
   assign read_issue = accept && (req_tuser == OP_READ) && pix_in_frame;

   fcbd_walk u_walk (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .crow  (row_in),
      .ccol  (col_in),
      .rad   (rad_in),
      .walk  (walk)
   );

   // Draw pixels are read while walked and written back on the next cycle.
   always_comb begin
      ram_wr_en   = load_write || wr_valid_ff;
      ram_wr_addr = load_write ? pix_addr : wr_addr_ff;
      ram_wr_data = load_write ? color_in : blend_px(rd_data, color_ff);
      ram_rd_en   = read_issue || (walk.valid && walk.hit);
      ram_rd_addr = read_issue ? pix_addr : walk.addr;
   end

   fcbd_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PIXELS)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            case (req_tuser)
               OP_READ: begin
                  if (pix_in_frame) begin
                     state_in = S_READ;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_pixel_in  = '0;
                     rsp_status_in = 1'b1;
                  end
               end
               OP_DRAW: state_in = S_DRAW;
               OP_LOAD: begin
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = '0;
                  rsp_status_in = !pix_in_frame;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_pixel_in  = '0;
                  rsp_status_in = 1'b0;
               end
            endcase
         end
         S_READ: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_pixel_in  = rd_data;
            rsp_status_in = 1'b0;
         end
         S_DRAW: if (walk.done) begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_pixel_in  = '0;
            rsp_status_in = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wr_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_valid_ff  <= walk.valid && walk.hit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
      wr_addr_ff    <= walk.addr;
      if (walk_start) begin
         color_ff <= color_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

>>> rtl/core/fcbd_checker.sv
// Port-level checker for the circle draw block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fcbd_checker
   import fcbd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [OP_W-1:0]       req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   logic load_beat, rsp_stall, rsp_error;
   assign load_beat = req_tvalid && req_tready && (req_tuser == OP_LOAD);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_error = rsp_tvalid && rsp_tuser;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid, "result beat dropped")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_tdata), "result data moved")
   `ASSERT_CLK(a_err_zero, clock, reset, rsp_error |-> rsp_tdata == '0, "error beat with data")
   `ASSERT_CLK(a_load_fast, clock, reset, load_beat |=> rsp_tvalid, "load result late")
   `ASSERT_NEVER(a_one_open, clock, reset, req_tready && rsp_stall, "request taken under stall")

endmodule

bind filled_circle_blend_draw fcbd_checker u_checker (.*);
`default_nettype wire

>>> tb/filled_circle_blend_draw_tb.sv
// Self-checking testbench for the filled circle draw block with average blending.
`timescale 1ns / 1ps
module filled_circle_blend_draw_tb;
   import fcbd_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
   localparam logic            STATUS_DONE  = 1'b0;
   localparam logic            STATUS_RANGE = 1'b1;
   localparam int COORD_MAX     = (1 << COORD_W) - 1;
   localparam int RANDOM_ITEMS  = 460;
   localparam int LOADED_EDGE   = 10;
   localparam int QUIET_LIMIT   = 300000;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_EVERY    = 700;
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] radius;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } pixel_cmd_type;

   typedef struct packed {
      logic              status;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_rsp_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // Shadow copy of the frame, one array per channel.
   logic [CHAN_W-1:0] frame_red   [PIXELS];
   logic [CHAN_W-1:0] frame_green [PIXELS];
   logic [CHAN_W-1:0] frame_blue  [PIXELS];

   // Pixels that some queued command has loaded; reads and draws stay on these.
   bit loaded [PIXELS];

   pixel_cmd_type cmd_backlog [$];
   pixel_rsp_type predicted_rsp_q [$];

   int  tx_idle_pct = 15;
   int  rx_idle_pct = 55;
   int  items_queued = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   int  next_hold_at = HOLD_EVERY;
   bit  req_taken = 1'b0;
   int  n_loads = 0, n_reads = 0, n_draws = 0, n_unused = 0, n_off_image = 0;
   longint n_blended = 0;

   filled_circle_blend_draw dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one command to the shadow frame and returns the result it must produce.
   function automatic pixel_rsp_type apply_pixel_cmd(input pixel_cmd_type cmd);
      pixel_rsp_type rsp;
      int crow, ccol, rad, rr, idx, p;
      int m_lo, m_hi, n_lo, n_hi;
      logic in_image;
      rsp  = '0;
      crow = cmd.row;
      ccol = cmd.col;
      rad  = cmd.radius;
      in_image = crow < IMAGE_HEIGHT && ccol < IMAGE_WIDTH;
      idx = crow * IMAGE_WIDTH + ccol;
      case (cmd.op)
         OP_LOAD: begin
            n_loads++;
            if (in_image) begin
               frame_red[idx]   = cmd.red;
               frame_green[idx] = cmd.green;
               frame_blue[idx]  = cmd.blue;
            end else begin
               rsp.status = STATUS_RANGE;
               n_off_image++;
            end
         end
         OP_READ: begin
            n_reads++;
            if (in_image) begin
               rsp.red   = frame_red[idx];
               rsp.green = frame_green[idx];
               rsp.blue  = frame_blue[idx];
            end else begin
               rsp.status = STATUS_RANGE;
               n_off_image++;
            end
         end
         OP_DRAW: begin
            n_draws++;
            rr   = rad * rad;
            m_lo = (-rad < -crow) ? -crow : -rad;
            m_hi = (rad > IMAGE_HEIGHT - 1 - crow) ? IMAGE_HEIGHT - 1 - crow : rad;
            n_lo = (-rad < -ccol) ? -ccol : -rad;
            n_hi = (rad > IMAGE_WIDTH - 1 - ccol) ? IMAGE_WIDTH - 1 - ccol : rad;
            for (int m = m_lo; m <= m_hi; m++) begin
               for (int n = n_lo; n <= n_hi; n++) begin
                  if (m * m + n * n <= rr) begin
                     p = (crow + m) * IMAGE_WIDTH + (ccol + n);
                     frame_red[p]   = CHAN_W'((9'(frame_red[p]) + 9'(cmd.red)) >> 1);
                     frame_green[p] = CHAN_W'((9'(frame_green[p]) + 9'(cmd.green)) >> 1);
                     frame_blue[p]  = CHAN_W'((9'(frame_blue[p]) + 9'(cmd.blue)) >> 1);
                     n_blended++;
                  end
               end
            end
         end
         default: n_unused++;
      endcase
      rsp.status = rsp.status | STATUS_DONE;
      return rsp;
   endfunction

   task automatic queue_pixel_cmd(input logic [OP_W-1:0] op, input int row, input int col,
                                  input int radius, input int red, input int green,
                                  input int blue);
      pixel_cmd_type cmd;
      cmd.op     = op;
      cmd.row    = COORD_W'(row);
      cmd.col    = COORD_W'(col);
      cmd.radius = COORD_W'(radius);
      cmd.red    = CHAN_W'(red);
      cmd.green  = CHAN_W'(green);
      cmd.blue   = CHAN_W'(blue);
      cmd_backlog.push_back(cmd);
      items_queued++;
      if (op == OP_LOAD && row < IMAGE_HEIGHT && col < IMAGE_WIDTH)
         loaded[row * IMAGE_WIDTH + col] = 1'b1;
   endtask

   // Mostly in-image coordinates with the edges favored; some beyond the image.
   function automatic int random_coord(input int limit, input bit allow_out);
      int pick;
      pick = $urandom_range(0, 99);
      if (allow_out && pick < 12)
         return $urandom_range(limit, COORD_MAX);
      else if (pick < 30)
         return $urandom_range(0, 1) ? $urandom_range(0, 3) : limit - 1 - $urandom_range(0, 3);
      else
         return $urandom_range(0, limit - 1);
   endfunction

   // A coordinate inside one of the two loaded corner blocks along an axis.
   function automatic int corner_coord(input int limit);
      return $urandom_range(0, 1) ? $urandom_range(0, LOADED_EDGE - 1)
                                  : limit - 1 - $urandom_range(0, LOADED_EDGE - 1);
   endfunction

   // True when every in-image pixel under the circle has been loaded.
   function automatic bit circle_loaded(input int crow, input int ccol, input int rad);
      int pr, pc;
      for (int m = -rad; m <= rad; m++) begin
         for (int n = -rad; n <= rad; n++) begin
            pr = crow + m;
            pc = ccol + n;
            if (m * m + n * n <= rad * rad && pr >= 0 && pr < IMAGE_HEIGHT &&
                pc >= 0 && pc < IMAGE_WIDTH && !loaded[pr * IMAGE_WIDTH + pc])
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic queue_random_cmds(input int count);
      int pick, op, row, col, radius, tries;
      bit fits;
      for (int i = 0; i < count; i++) begin
         pick   = $urandom_range(0, 99);
         row    = random_coord(IMAGE_HEIGHT, 1'b1);
         col    = random_coord(IMAGE_WIDTH, 1'b1);
         radius = $urandom_range(0, COORD_MAX);
         if (pick < 30) begin
            op = OP_LOAD;
         end else if (pick < 55) begin
            op = OP_READ;
            // In-image reads go to loaded pixels only.
            if (row < IMAGE_HEIGHT && col < IMAGE_WIDTH && !loaded[row * IMAGE_WIDTH + col]) begin
               row = corner_coord(IMAGE_HEIGHT);
               col = corner_coord(IMAGE_WIDTH);
            end
         end else if (pick < 88) begin
            // Small circles over loaded corners, sometimes centered past the bottom or right.
            op    = OP_DRAW;
            tries = 0;
            fits  = 1'b0;
            while (!fits && tries < 40) begin
               radius = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                                     : $urandom_range(7, 20);
               row    = corner_coord(IMAGE_HEIGHT);
               col    = corner_coord(IMAGE_WIDTH);
               if ($urandom_range(0, 99) < 10)
                  row = IMAGE_HEIGHT + $urandom_range(0, radius);
               else if ($urandom_range(0, 99) < 10)
                  col = IMAGE_WIDTH + $urandom_range(0, radius);
               fits = circle_loaded(row, col, radius);
               tries++;
            end
            if (!fits) begin
               radius = 0;
               row    = corner_coord(IMAGE_HEIGHT);
               col    = corner_coord(IMAGE_WIDTH);
            end
         end else if (pick < 95) begin
            // Circles far enough off the image that the clipped square is empty.
            op = OP_DRAW;
            if ($urandom_range(0, 1)) begin
               row    = $urandom_range(IMAGE_HEIGHT, COORD_MAX);
               radius = $urandom_range(0, row - IMAGE_HEIGHT);
            end else begin
               col    = $urandom_range(IMAGE_WIDTH, COORD_MAX);
               radius = $urandom_range(0, col - IMAGE_WIDTH);
            end
         end else begin
            op = OP_UNUSED;
         end
         queue_pixel_cmd(OP_W'(op), row, col, radius, $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   task automatic await_results();
      while (results_seen != items_queued)
         @(negedge clock);
   endtask

   // Request side: a new beat is offered only once the previous one was taken.
   always @(negedge clock) begin
      pixel_cmd_type cmd;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            cmd = cmd_backlog.pop_front();
            req_tdata  <= {2'b00, cmd.blue, cmd.green, cmd.red, cmd.radius, cmd.col, cmd.row};
            req_tuser  <= cmd.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: random stalls plus a long hold-off every so many results.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (results_seen >= next_hold_at) begin
         rsp_tready   <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + HOLD_EVERY;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Predict on every accepted request beat and check every accepted result beat.
   always @(posedge clock) begin
      pixel_cmd_type cmd;
      pixel_rsp_type want, got;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         cmd.op     = req_tuser;
         cmd.row    = req_tdata[9:0];
         cmd.col    = req_tdata[19:10];
         cmd.radius = req_tdata[29:20];
         cmd.red    = req_tdata[37:30];
         cmd.green  = req_tdata[45:38];
         cmd.blue   = req_tdata[53:46];
         predicted_rsp_q.push_back(apply_pixel_cmd(cmd));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.red    = rsp_tdata[7:0];
         got.green  = rsp_tdata[15:8];
         got.blue   = rsp_tdata[23:16];
         got.status = rsp_tuser;
         if (predicted_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result beat %0d: r=%02h g=%02h b=%02h status=%0b",
                        results_seen, got.red, got.green, got.blue, got.status);
         end else begin
            want = predicted_rsp_q.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result %0d mismatch: expected r=%02h g=%02h b=%02h status=%0b, %s",
                           results_seen, want.red, want.green, want.blue, want.status,
                           $sformatf("got r=%02h g=%02h b=%02h status=%0b",
                                     got.red, got.green, got.blue, got.status));
            end
         end
      end
   end

   // Watchdog on cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d cycles without a beat", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The four corner blocks are loaded first, so reads and draws touch defined data.
      for (int r = 0; r < IMAGE_HEIGHT; r++)
         for (int c = 0; c < IMAGE_WIDTH; c++)
            if ((r < LOADED_EDGE || r >= IMAGE_HEIGHT - LOADED_EDGE) &&
                (c < LOADED_EDGE || c >= IMAGE_WIDTH - LOADED_EDGE))
               queue_pixel_cmd(OP_LOAD, r, c, $urandom_range(0, COORD_MAX),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));

      // Corner pixels with extreme colors.
      queue_pixel_cmd(OP_LOAD, 0, 0, 0, 255, 255, 255);
      queue_pixel_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
      queue_pixel_cmd(OP_LOAD, IMAGE_HEIGHT - 1, IMAGE_WIDTH - 1, COORD_MAX, 0, 0, 0);
      queue_pixel_cmd(OP_READ, IMAGE_HEIGHT - 1, IMAGE_WIDTH - 1, COORD_MAX, 255, 255, 255);
      // Loads and reads beyond the image report a range error.
      queue_pixel_cmd(OP_LOAD, IMAGE_HEIGHT, 0, 1, 18, 52, 86);
      queue_pixel_cmd(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, 255, 255, 255);
      queue_pixel_cmd(OP_READ, 0, IMAGE_WIDTH, 0, 0, 0, 0);
      queue_pixel_cmd(OP_READ, COORD_MAX, 0, 0, 0, 0, 0);
      // Zero radius blends the center pixel only.
      queue_pixel_cmd(OP_DRAW, 5, 5, 0, 255, 0, 128);
      queue_pixel_cmd(OP_READ, 5, 5, 0, 0, 0, 0);
      // Unit circle on the corner, partly clipped.
      queue_pixel_cmd(OP_DRAW, 0, 0, 1, 0, 255, 0);
      queue_pixel_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
      queue_pixel_cmd(OP_READ, 1, 0, 0, 0, 0, 0);
      // Center below the image with only the top of the circle reaching in.
      queue_pixel_cmd(OP_DRAW, IMAGE_HEIGHT + 2, IMAGE_WIDTH - 5, 3, 200, 100, 50);
      queue_pixel_cmd(OP_READ, IMAGE_HEIGHT - 1, IMAGE_WIDTH - 5, 0, 0, 0, 0);
      // Center past the bottom right corner with a small cap inside the image.
      queue_pixel_cmd(OP_DRAW, IMAGE_HEIGHT + 5, IMAGE_WIDTH + 5, 9, 90, 60, 30);
      queue_pixel_cmd(OP_READ, IMAGE_HEIGHT - 1, IMAGE_WIDTH - 1, 0, 0, 0, 0);
      // Largest radius: the square spans the whole frame but the circle misses it.
      queue_pixel_cmd(OP_DRAW, COORD_MAX, COORD_MAX, COORD_MAX, 255, 255, 255);
      // Off-image center whose clipped square is empty.
      queue_pixel_cmd(OP_DRAW, 600, 40, 344, 1, 2, 3);
      queue_pixel_cmd(OP_UNUSED, COORD_MAX, COORD_MAX, COORD_MAX, 255, 255, 255);
      queue_pixel_cmd(OP_READ, 0, IMAGE_WIDTH - 1, 0, 0, 0, 0);
      queue_pixel_cmd(OP_READ, IMAGE_HEIGHT - 1, 0, 0, 0, 0, 0);
      queue_random_cmds(RANDOM_ITEMS);
      await_results();

      tx_idle_pct = 55;
      rx_idle_pct = 15;
      queue_random_cmds(RANDOM_ITEMS);
      await_results();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      queue_random_cmds(RANDOM_ITEMS);
      await_results();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (predicted_rsp_q.size() != 0) begin
         $display("%0d results never arrived", predicted_rsp_q.size());
         mismatches += predicted_rsp_q.size();
      end
      $display("Covered %0d loads, %0d reads, %0d circle draws and %0d unused operations.",
               n_loads, n_reads, n_draws, n_unused);
      $display("%0d pixels blended, %0d off-image loads and reads, %0d mismatching beats.",
               n_blended, n_off_image, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
